// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the upscaler RTL.
// Clock aclk and active-low reset aresetn are assumed in the user's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked check with explicit clock and reset.
`define PXUP_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check on the block clock, off during reset.
`define PXUP_ASSERT(label, prop, msg) \
    `PXUP_ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== rtl/pxup_pkg.sv =====
// Package for the 2x pixel-art edge upscaler: block job type, sizes and
// color-distance constants. No dependencies.
`default_nettype none

package pxup_pkg;

    localparam int unsigned SZW         = 14;   // wide enough for sizes up to 8192
    localparam int unsigned COORD_W     = 11;
    localparam int unsigned PIX_W       = 32;
    localparam int unsigned THR_W       = 19;
    localparam int unsigned CFG_W       = 19;
    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned DIM_W       = 12;
    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD    = 2'd2;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd240;
    localparam logic [THR_W-1:0] RST_THRESHOLD    = 19'd1296;

    // Division by 1000 as multiply by ceil(2^28/1000) and shift; exact for |x| <= 255000.
    localparam logic [18:0] DIV1000_K     = 19'd268436;
    localparam int unsigned DIV1000_SHIFT = 28;

    localparam logic [PIX_W-1:0] HALF_MASK = 32'h7F7F_7F7F;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   m;
        logic [PIX_W-1:0]   up;
        logic [PIX_W-1:0]   dn;
        logic [PIX_W-1:0]   lt;
        logic [PIX_W-1:0]   rt;
        logic               last;
    } job_t;

    function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
        mix = ((a >> 1) & HALF_MASK) + ((b >> 1) & HALF_MASK);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pxup_fifo.sv =====
// Short job queue between the front and back parts of the upscaler.
// Depends on pxup_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pxup_fifo
    import pxup_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  job_t      push_data,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_data,
    output logic      empty
);
    job_t                mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    `PXUP_ASSERT(a_no_push_full, !(push && full), "job pushed into full queue")
    `PXUP_ASSERT(a_no_pop_empty, !(pop && empty), "job popped from empty queue")

endmodule

`default_nettype wire

// ===== rtl/pxup_front.sv =====
// Front part: accepts pixels, tracks position, keeps line stores and window,
// and queues up to three block jobs per pixel. Depends on pxup_pkg.
`default_nettype none
`include "assert_macros.svh"

module pxup_front
    import pxup_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  pixel,
    input  wire logic [DIM_W-1:0]  frame_width,
    input  wire logic [DIM_W-1:0]  frame_height,
    output logic                   push,
    output job_t                   push_data,
    input  wire logic              full
);
    localparam int unsigned CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int unsigned HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_READ = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [PIX_W-1:0] prev_mem [MAX_WIDTH];
    logic [PIX_W-1:0] old_mem  [MAX_WIDTH];

    logic [CW-1:0]    col_reg, c_reg;
    logic [HW-1:0]    row_reg, r_reg;
    logic [PIX_W-1:0] px_reg, p_rd_reg, pr_rd_reg, o_rd_reg;
    logic [PIX_W-1:0] win0_reg, win1_reg, win2_reg;
    job_t             job_reg [3];
    logic [2:0]       en_reg;

    logic [SZW-1:0] w, h;
    logic [SZW-1:0] c0x, r0x, cnx, rnx;
    logic [CW-1:0]  c0, c1;
    logic [HW-1:0]  r0;
    logic           accept;

    assign w = (frame_width == '0) ? SZW'(1) :
               (SZW'(frame_width) > SZW'(MAX_WIDTH)) ? SZW'(MAX_WIDTH) : SZW'(frame_width);
    assign h = (frame_height == '0) ? SZW'(1) :
               (SZW'(frame_height) > SZW'(MAX_HEIGHT)) ? SZW'(MAX_HEIGHT) : SZW'(frame_height);

    assign s_tready = (state_reg == F_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Position of the incoming pixel and of the next one.
    always_comb begin
        c0x = SZW'(col_reg);
        r0x = SZW'(row_reg);
        if (c0x >= w) begin
            c0x = '0;
            r0x = r0x + 1'b1;
        end
        if (r0x >= h) r0x = '0;
        cnx = c0x + 1'b1;
        rnx = r0x;
        if (cnx >= w) begin
            cnx = '0;
            rnx = r0x + 1'b1;
            if (rnx >= h) rnx = '0;
        end
        c0 = CW'(c0x);
        r0 = HW'(r0x);
        c1 = ((c0x + 1'b1) < w) ? CW'(c0x + 1'b1) : c0;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_rd_reg  <= prev_mem[c0];
            pr_rd_reg <= prev_mem[c1];
        end
        if (state_reg == F_READ) begin
            prev_mem[c_reg] <= px_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            o_rd_reg <= old_mem[c0];
        end
        if (state_reg == F_READ) begin
            old_mem[c_reg] <= p_rd_reg;
        end
    end

    // Block jobs for the pixel just read.
    logic [SZW-1:0]   cx, rx;
    logic [PIX_W-1:0] pr;
    logic [2:0]       en_new;
    job_t             ja, jb, jc;
    always_comb begin
        cx = SZW'(c_reg);
        rx = SZW'(r_reg);
        pr = ((cx + 1'b1) < w) ? pr_rd_reg : p_rd_reg;
        en_new[0] = (rx >= SZW'(1));
        en_new[1] = (rx == h - 1'b1) && (cx >= SZW'(1));
        en_new[2] = (rx == h - 1'b1) && (cx == w - 1'b1);

        ja.col = COORD_W'(c_reg);
        ja.row = COORD_W'(r_reg - 1'b1);
        ja.m   = p_rd_reg;
        ja.up  = (rx >= SZW'(2)) ? o_rd_reg : p_rd_reg;
        ja.dn  = px_reg;
        ja.lt  = (cx > '0) ? win0_reg : p_rd_reg;
        ja.rt  = pr;
        ja.last = !en_new[1] && !en_new[2];

        jb.col = COORD_W'(c_reg - 1'b1);
        jb.row = COORD_W'(r_reg);
        jb.m   = win1_reg;
        jb.up  = (rx > '0) ? win0_reg : win1_reg;
        jb.dn  = win1_reg;
        jb.lt  = (cx >= SZW'(2)) ? win2_reg : win1_reg;
        jb.rt  = px_reg;
        jb.last = !en_new[2];

        jc.col = COORD_W'(c_reg);
        jc.row = COORD_W'(r_reg);
        jc.m   = px_reg;
        jc.up  = (rx > '0) ? p_rd_reg : px_reg;
        jc.dn  = px_reg;
        jc.lt  = (cx > '0) ? win1_reg : px_reg;
        jc.rt  = px_reg;
        jc.last = 1'b1;
    end

    logic [1:0] sel;
    always_comb begin
        sel = en_reg[0] ? 2'd0 : (en_reg[1] ? 2'd1 : 2'd2);
    end
    assign push      = (state_reg == F_PUSH) && (en_reg != '0) && !full;
    assign push_data = job_reg[sel];

    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg <= pixel;
            c_reg  <= c0;
            r_reg  <= r0;
        end
        if (state_reg == F_READ) begin
            job_reg[0] <= ja;
            job_reg[1] <= jb;
            job_reg[2] <= jc;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (accept) state_next = F_READ;
            F_READ: state_next = (en_new != '0) ? F_PUSH : F_IDLE;
            F_PUSH: if (push && ((en_reg & ~(3'b001 << sel)) == '0)) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            win0_reg  <= '0;
            win1_reg  <= '0;
            win2_reg  <= '0;
            en_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                col_reg <= CW'(cnx);
                row_reg <= HW'(rnx);
            end
            if (state_reg == F_READ) begin
                en_reg   <= en_new;
                win2_reg <= win1_reg;
                win1_reg <= px_reg;
                win0_reg <= p_rd_reg;
            end else if (push) begin
                en_reg <= en_reg & ~(3'b001 << sel);
            end
        end
    end

    `PXUP_ASSERT(a_accept_reads, accept |=> (state_reg == F_READ), "read step skipped")

endmodule

`default_nettype wire

// ===== rtl/pxup_sim.sv =====
// Three-stage similarity unit: weighted YCbCr distance of two pixels
// compared against the threshold. Depends on pxup_pkg.
`default_nettype none

module pxup_sim
    import pxup_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    input  wire logic [2:0]       in_tag,
    input  wire logic [PIX_W-1:0] a,
    input  wire logic [PIX_W-1:0] b,
    input  wire logic [THR_W-1:0] threshold,
    output logic                  out_valid,
    output logic [2:0]            out_tag,
    output logic                  out_similar
);
    logic signed [19:0] dr, dg, db, y, cb, cr;
    logic [17:0] ay, acb, acr;

    always_comb begin
        dr = 20'(signed'({1'b0, a[7:0]})   - signed'({1'b0, b[7:0]}));
        dg = 20'(signed'({1'b0, a[15:8]})  - signed'({1'b0, b[15:8]}));
        db = 20'(signed'({1'b0, a[23:16]}) - signed'({1'b0, b[23:16]}));
        y  = dr * 20'sd299  + dg * 20'sd587  + db * 20'sd114;
        cb = dr * -20'sd169 - dg * 20'sd331  + db * 20'sd500;
        cr = dr * 20'sd500  - dg * 20'sd418  - db * 20'sd81;
        ay  = 18'(y[19]  ? -y  : y);
        acb = 18'(cb[19] ? -cb : cb);
        acr = 18'(cr[19] ? -cr : cr);
    end

    logic [17:0] ay_reg, acb_reg, acr_reg;
    logic [7:0]  qy_reg, qcb_reg, qcr_reg;
    logic [36:0] py, pcb, pcr;
    logic [15:0] sq_y, sq_cb, sq_cr;
    logic [18:0] dist_sum;
    logic        v1_reg, v2_reg;
    logic [2:0]  t1_reg, t2_reg;

    // Only magnitudes matter: every quotient is squared.
    assign py  = 37'(ay_reg)  * 37'(DIV1000_K);
    assign pcb = 37'(acb_reg) * 37'(DIV1000_K);
    assign pcr = 37'(acr_reg) * 37'(DIV1000_K);
    assign sq_y  = 16'(qy_reg)  * 16'(qy_reg);
    assign sq_cb = 16'(qcb_reg) * 16'(qcb_reg);
    assign sq_cr = 16'(qcr_reg) * 16'(qcr_reg);
    assign dist_sum = {1'b0, sq_y, 2'b00} + 19'(sq_cb) + 19'(sq_cr);

    always_ff @(posedge aclk) begin
        ay_reg  <= ay;
        acb_reg <= acb;
        acr_reg <= acr;
        t1_reg  <= in_tag;
        qy_reg  <= 8'(py  >> DIV1000_SHIFT);
        qcb_reg <= 8'(pcb >> DIV1000_SHIFT);
        qcr_reg <= 8'(pcr >> DIV1000_SHIFT);
        t2_reg  <= t1_reg;
        out_tag <= t2_reg;
        out_similar <= (dist_sum < threshold);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= v2_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pxup_back.sv =====
// Back part: pops block jobs, runs eight similarity tests through the
// shared unit, forms the 2x2 block and holds it in the output register.
// Depends on pxup_pkg, pxup_sim and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pxup_back
    import pxup_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [THR_W-1:0] threshold,
    input  wire logic             empty,
    input  job_t                  pop_data,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [151:0]          m_tdata,
    output logic                  m_tlast
);
    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_ISSUE = 4'b0010,
        B_WAIT  = 4'b0100,
        B_OUT   = 4'b1000
    } bstate_t;

    localparam logic [2:0] PR_LR = 3'd0;
    localparam logic [2:0] PR_UD = 3'd1;
    localparam logic [2:0] PR_UL = 3'd2;
    localparam logic [2:0] PR_UR = 3'd3;
    localparam logic [2:0] PR_DL = 3'd4;
    localparam logic [2:0] PR_DR = 3'd5;
    localparam logic [2:0] PR_UM = 3'd6;
    localparam logic [2:0] PR_DM = 3'd7;

    bstate_t          state_reg, state_next;
    job_t             job_reg;
    logic [2:0]       k_reg;
    logic [7:0]       sim_reg;
    logic [PIX_W-1:0] pa, pb;
    logic             res_valid, res_sim;
    logic [2:0]       res_tag;

    assign pop = (state_reg == B_IDLE) && !empty;

    always_comb begin
        case (k_reg)
            PR_LR:   begin pa = job_reg.lt; pb = job_reg.rt; end
            PR_UD:   begin pa = job_reg.up; pb = job_reg.dn; end
            PR_UL:   begin pa = job_reg.up; pb = job_reg.lt; end
            PR_UR:   begin pa = job_reg.up; pb = job_reg.rt; end
            PR_DL:   begin pa = job_reg.dn; pb = job_reg.lt; end
            PR_DR:   begin pa = job_reg.dn; pb = job_reg.rt; end
            PR_UM:   begin pa = job_reg.up; pb = job_reg.m;  end
            PR_DM:   begin pa = job_reg.dn; pb = job_reg.m;  end
            default: begin pa = job_reg.m;  pb = job_reg.m;  end
        endcase
    end

    pxup_sim u_sim (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (state_reg == B_ISSUE),
        .in_tag      (k_reg),
        .a           (pa),
        .b           (pb),
        .threshold   (threshold),
        .out_valid   (res_valid),
        .out_tag     (res_tag),
        .out_similar (res_sim)
    );

    logic             flat;
    logic [PIX_W-1:0] tl, tr, bl, br;
    logic [7:0]       s;
    always_comb begin
        s = sim_reg;
        s[res_tag] = res_sim;
        flat = !s[PR_LR] && !s[PR_UD];
        tl = (flat && s[PR_UL] && !s[PR_UM]) ? mix(job_reg.up, job_reg.lt) : job_reg.m;
        tr = (flat && s[PR_UR] && !s[PR_UM]) ? mix(job_reg.up, job_reg.rt) : job_reg.m;
        bl = (flat && s[PR_DL] && !s[PR_DM]) ? mix(job_reg.dn, job_reg.lt) : job_reg.m;
        br = (flat && s[PR_DR] && !s[PR_DM]) ? mix(job_reg.dn, job_reg.rt) : job_reg.m;
    end

    logic done;
    assign done = (state_reg == B_WAIT) && res_valid && (res_tag == PR_DM);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:  if (pop) state_next = B_ISSUE;
            B_ISSUE: if (k_reg == PR_DM) state_next = B_WAIT;
            B_WAIT:  if (done) state_next = B_OUT;
            B_OUT:   if (m_tready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) job_reg <= pop_data;
        if (res_valid) sim_reg[res_tag] <= res_sim;
        if (done) begin
            m_tdata <= {2'b00, br, bl, tr, tl, job_reg.row, job_reg.col};
            m_tlast <= job_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == B_ISSUE) k_reg <= k_reg + 1'b1;
            else k_reg <= '0;
        end
    end

    assign m_tvalid = (state_reg == B_OUT);

    `PXUP_ASSERT(a_result_in_job, res_valid |-> (state_reg == B_ISSUE || state_reg == B_WAIT),
                 "similarity result outside a job")

endmodule

`default_nettype wire

// ===== rtl/pixel_art_edge_upscale_2x_top.sv =====
// Top level of the 2x pixel-art edge upscaler: configuration registers,
// front part, job queue and back part. Depends on pxup_pkg and submodules.
//
// Usage:
//  - s_ channel carries source pixels in raster order (byte0 R, byte1 G,
//    byte2 B, byte3 alpha). m_ channel carries one 2x2 block per transaction
//    with its source column and row; tlast marks the last block caused by
//    one input pixel. A pixel of row r releases the block of row r-1 above
//    it; last-row pixels also release the left block, the last its own.
//  - Configuration: write frame_width, frame_height or similarity_threshold
//    through cfg_wr_en/cfg_addr/cfg_wr_data while the block is idle.
//  - Flow: the front takes each pixel in its idle and read states, then
//    pushes each of its blocks (up to 3) in the push state, waiting while
//    the queue is full, and takes no new pixel before that. In the back
//    part, eight similarity tests go one per cycle through the shared
//    3-stage similarity pipeline, then the block is held in the output
//    register.
//  - Reset (synchronous, aresetn low): clear position, window, queue and
//    restore 320x240 and threshold 1296. Line stores are not cleared.
//  - Stall: when m_tready is low, hold the block; the queue absorbs up to
//    four jobs, then the front stops taking pixels (s_tready low).
`default_nettype none

module pixel_art_edge_upscale_2x_top
    import pxup_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,     // [31:0] pixel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [10:0] src_col, [21:11] src_row, [53:22] top_left, [85:54] top_right,
    // [117:86] bottom_left, [149:118] bottom_right, [151:150] zero
    output logic [151:0]               m_tdata,
    output logic                       m_tlast,     // last_of_run
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_wr_data
);
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [THR_W-1:0] threshold_reg;

    // Take configuration writes; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            threshold_reg    <= RST_THRESHOLD;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[DIM_W-1:0];
                REG_THRESHOLD:    threshold_reg    <= cfg_wr_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    job_t q_in, q_out;
    logic q_push, q_full, q_pop, q_empty;

    // Front: position, line stores, window, job generation.
    pxup_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .pixel        (s_tdata),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .push         (q_push),
        .push_data    (q_in),
        .full         (q_full)
    );

    // Queue: decouple pixel intake from block evaluation.
    pxup_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Back: similarity tests, corner blending, output register.
    pxup_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .threshold (threshold_reg),
        .empty     (q_empty),
        .pop_data  (q_out),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
